>>> hw/rtl/unsigned_to_radix_digits_assert.svh
// assertion macros for the radix digit converter
// used by the top level only, needs a clock named clock and a reset named reset
`ifndef UNSIGNED_TO_RADIX_DIGITS_ASSERT_SVH
`define UNSIGNED_TO_RADIX_DIGITS_ASSERT_SVH

// same-cycle implication
`define URD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define URD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/urd_pkg.sv
// shared types, constants and helper functions for the radix digit converter
// no dependencies
`default_nettype none

package urd_pkg;

   localparam int VALUE_W            = 32;
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int BASE_W             = 6;
   localparam int CHAR_W             = 7;

   localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
   localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
   localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
   localparam logic [BASE_W-1:0] DEC_DIGITS = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA  = 7'h41;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_EMIT
   } urd_state_type;

   typedef struct packed {
      logic done;
      logic quot_zero;
   } div_status_type;

   function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] raw);
      logic [BASE_W-1:0] res;
      if (raw < BASE_MIN) begin
         res = BASE_MIN;
      end else if (raw > BASE_MAX) begin
         res = BASE_MAX;
      end else begin
         res = raw;
      end
      return res;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] d);
      logic [CHAR_W-1:0] res;
      if (d < DEC_DIGITS) begin
         res = CHAR_ZERO + {1'b0, d};
      end else begin
         res = CHAR_ALPHA + {1'b0, d} - {1'b0, DEC_DIGITS};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/urd_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on urd_pkg
`default_nettype none

module urd_divider #(
   parameter int VALUE_BITS = urd_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [VALUE_BITS-1:0]         dividend,
   input  wire logic [urd_pkg::BASE_W-1:0]    base,
   output logic      [VALUE_BITS-1:0]         quotient,
   output logic      [urd_pkg::BASE_W-1:0]    remainder,
   output urd_pkg::div_status_type            status
);

   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0]        quot_ff, quot_in;
   logic [urd_pkg::BASE_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         done_ff, done_in;
   logic [urd_pkg::BASE_W:0]     trial;
   logic [urd_pkg::BASE_W:0]     diff;
   logic                         ge;

   always_comb begin
      trial = {rem_ff, quot_ff[VALUE_BITS-1]};
      ge    = trial >= {1'b0, base};
      diff  = trial - {1'b0, base};
   end

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(VALUE_BITS);
      end else if (cnt_ff != '0) begin
         quot_in = {quot_ff[VALUE_BITS-2:0], ge};
         rem_in  = ge ? diff[urd_pkg::BASE_W-1:0] : trial[urd_pkg::BASE_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign quotient         = quot_ff;
   assign remainder        = rem_ff;
   assign status.done      = done_ff;
   assign status.quot_zero = (quot_ff == '0);

endmodule

`default_nettype wire

>>> hw/rtl/urd_digit_stack.sv
// digit store, written least significant first and read back in reverse
// depends on urd_pkg
`default_nettype none

module urd_digit_stack #(
   parameter int DEPTH = urd_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire logic [urd_pkg::BASE_W-1:0]    wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic      [urd_pkg::BASE_W-1:0]    rd_data
);

   logic [urd_pkg::BASE_W-1:0] mem [DEPTH];
   logic [urd_pkg::BASE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/unsigned_to_radix_digits.sv
// top level: unsigned value to ascii digits in a programmable radix
// depends on urd_pkg, urd_divider, urd_digit_stack, unsigned_to_radix_digits_assert.svh
//
// channel   ports                              transaction
// req       req_valid/req_ready, req_value     one value to convert
// rsp       rsp_valid/rsp_ready, rsp_digit_*   one digit, most significant first
// csr       csr_write_enable, csr_write_data   radix write, clamped to 2..36
//
// each digit is produced by the bit-serial divider and pushed on the stack; the
// stack is then read back out through the READ and EMIT states, most significant
// digit first. synchronous reset, radix returns to 10. a stalled rsp holds the
// output register; the next req is taken while the final digit still waits.
`default_nettype none

module unsigned_to_radix_digits #(
   parameter int VALUE_BITS = urd_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [urd_pkg::VALUE_W-1:0]   req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [urd_pkg::CHAR_W-1:0]    rsp_digit_char,
   output logic                               rsp_last_digit,
   input  wire logic                          csr_write_enable,
   input  wire logic [urd_pkg::BASE_W-1:0]    csr_write_data
);

   localparam int CNT_W  = $clog2(VALUE_BITS + 1);
   localparam int ADDR_W = $clog2(VALUE_BITS);

   urd_pkg::urd_state_type       state_ff, state_in;
   logic [urd_pkg::BASE_W-1:0]   base_ff, base_in;
   logic [CNT_W-1:0]             digit_cnt_ff, digit_cnt_in;
   logic [CNT_W-1:0]             cnt_dec;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [urd_pkg::CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [VALUE_BITS-1:0]        value_ext;
   logic [VALUE_BITS-1:0]        dividend;
   logic [VALUE_BITS-1:0]        quotient;
   logic [urd_pkg::BASE_W-1:0]   remainder;
   urd_pkg::div_status_type      div_status;
   logic [urd_pkg::BASE_W-1:0]   stack_rd_data;

   logic                         accept;
   logic                         div_start;
   logic                         push;
   logic                         pop;
   logic                         rsp_load;

   generate
      if (VALUE_BITS > urd_pkg::VALUE_W) begin : g_wide
         assign value_ext = {{(VALUE_BITS - urd_pkg::VALUE_W){1'b0}}, req_value};
      end else if (VALUE_BITS == urd_pkg::VALUE_W) begin : g_equal
         assign value_ext = req_value;
      end else begin : g_narrow
         assign value_ext = req_value[VALUE_BITS-1:0];
      end
   endgenerate

   assign accept   = req_valid && req_ready;
   assign dividend = (state_ff == urd_pkg::ST_IDLE) ? value_ext : quotient;
   assign cnt_dec  = digit_cnt_ff - CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         urd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = urd_pkg::ST_DIVIDE;
            end
         end
         urd_pkg::ST_DIVIDE: begin
            if (div_status.done && div_status.quot_zero) begin
               state_in = urd_pkg::ST_READ;
            end
         end
         urd_pkg::ST_READ: begin
            state_in = urd_pkg::ST_EMIT;
         end
         urd_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = (digit_cnt_ff == '0) ? urd_pkg::ST_IDLE : urd_pkg::ST_READ;
            end
         end
         default: begin
            state_in = urd_pkg::ST_IDLE;
         end
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      push      = 1'b0;
      pop       = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         urd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            div_start = req_valid;
         end
         urd_pkg::ST_DIVIDE: begin
            push      = div_status.done;
            div_start = div_status.done && !div_status.quot_zero;
         end
         urd_pkg::ST_READ: begin
            pop = 1'b1;
         end
         urd_pkg::ST_EMIT: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      digit_cnt_in = digit_cnt_ff;
      if (accept) begin
         digit_cnt_in = '0;
      end else if (push) begin
         digit_cnt_in = digit_cnt_ff + CNT_W'(1);
      end else if (pop) begin
         digit_cnt_in = cnt_dec;
      end
   end

   always_comb begin
      base_in = base_ff;
      if (csr_write_enable) begin
         base_in = urd_pkg::clamp_base(csr_write_data);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load) begin
         rsp_char_in = urd_pkg::digit_to_char(stack_rd_data);
         rsp_last_in = (digit_cnt_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= urd_pkg::ST_IDLE;
         base_ff      <= urd_pkg::BASE_RESET;
         digit_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         digit_cnt_ff <= digit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   urd_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dividend),
      .base      (base_ff),
      .quotient  (quotient),
      .remainder (remainder),
      .status    (div_status)
   );

   urd_digit_stack #(
      .DEPTH (VALUE_BITS)
   ) u_digit_stack (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (digit_cnt_ff[ADDR_W-1:0]),
      .wr_data (remainder),
      .rd_en   (pop),
      .rd_addr (cnt_dec[ADDR_W-1:0]),
      .rd_data (stack_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

`include "unsigned_to_radix_digits_assert.svh"

   `URD_ASSERT_NOW(a_base_range, 1'b1, (base_ff >= urd_pkg::BASE_MIN) && (base_ff <= urd_pkg::BASE_MAX), "radix register out of range")
   `URD_ASSERT_NOW(a_cnt_bound, 1'b1, digit_cnt_ff <= CNT_W'(VALUE_BITS), "digit count beyond capacity")
   `URD_ASSERT_NOW(a_rem_below_base, push, remainder < base_ff, "digit not below radix")
   `URD_ASSERT_NEXT(a_accept_divides, accept, state_ff == urd_pkg::ST_DIVIDE, "accepted value not divided")

endmodule

`default_nettype wire
